/* rtl/sihash_pkg.sv */
`default_nettype none
package sihash_pkg;

  // fixed field widths, hash start value and fill limit reset value
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned SLOTID_W = 10;
  localparam logic [31:0] HASH_START = 32'd5381;
  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RST = 11'd512;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [SLOTID_W-1:0] slot_id;
    logic [31:0]         name_hash;
    status_e             status;
  } res_word_t;

endpackage
`default_nettype wire

/* rtl/string_intern_hash_table_unit.sv */
// a non-final character is accepted in idle; busy stays low for it
// a final character: each probed slot is read (PROBE) and checked (CHECK);
// a hash/length hit compares each character (CMP, CMPCHK); insertion copies each character (COPY, COPYWR)
// sequencer shares one slot memory port and one character compare/copy path
// reset: async active low; then a clearing pass over every slot of the
// slot table with busy high; the receiver cannot stall the result strobe
`default_nettype none
module string_intern_hash_table_unit #(
  parameter int unsigned SLOTS       = 1024,
  parameter int unsigned MAX_LEN     = 255,
  parameter int unsigned STORE_BYTES = 16384
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  sihash_pkg::in_word_t                in_i,
  output logic                                result_valid_o,
  output sihash_pkg::res_word_t               res_o,
  input  logic                                cfg_we_i,
  input  logic [sihash_pkg::LIMIT_W-1:0]      cfg_data_i
);
  import sihash_pkg::*;

  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned N_W      = SLOT_W + 1;
  localparam int unsigned STORE_AW = $clog2(STORE_BYTES);
  localparam int unsigned FILL_W   = $clog2(STORE_BYTES + 1);
  localparam int unsigned CMP_W    = ((N_W > LIMIT_W) ? N_W : LIMIT_W) + 1;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b00000001,
    S_IDLE    = 8'b00000010,
    S_PROBE   = 8'b00000100,
    S_CHECK   = 8'b00001000,
    S_CMP     = 8'b00010000,
    S_CMPCHK  = 8'b00100000,
    S_COPY    = 8'b01000000,
    S_COPYWR  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic                slot_vld_mem   [SLOTS];
  logic [31:0]         slot_hash_mem  [SLOTS];
  logic [LEN_W-1:0]    slot_len_mem   [SLOTS];
  logic [STORE_AW-1:0] slot_start_mem [SLOTS];
  logic [7:0]          char_mem       [STORE_BYTES];
  logic [7:0]          nbuf_mem       [256];

  logic                slot_vld_q;
  logic [31:0]         slot_hash_q;
  logic [LEN_W-1:0]    slot_len_q;
  logic [STORE_AW-1:0] slot_start_q;
  logic [7:0]          char_rd_q, nbuf_rd_q;

  // control and datapath registers
  logic [LIMIT_W-1:0] fill_limit_q;
  logic [31:0]        hash_q, hash_d;
  logic [8:0]         cnt_q, cnt_d;
  logic [31:0]        name_hash_q, name_hash_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [N_W-1:0]     n_q, n_d;
  logic [LEN_W-1:0]   i_q, i_d;
  logic [N_W-1:0]     used_q, used_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  logic               out_vld_q, out_vld_d;
  res_word_t          res_q, res_d;

  logic               acc;
  logic [31:0]        hash_new;
  logic [8:0]         cnt_new;
  logic               nbuf_we;
  logic               slot_we, slot_ins;
  logic               char_we;
  logic [STORE_AW-1:0] char_rd_addr, char_wr_addr;
  logic [FILL_W:0]    fill_sum;
  logic [CMP_W-1:0]   used_inc, limit_ext;
  logic               last_char;
  logic [31:0]        idx_ext;

  assign busy           = (state_q != S_IDLE);
  assign acc            = start && (state_q == S_IDLE);
  assign result_valid_o = out_vld_q;
  assign res_o          = res_q;

  // running hash: h*33 xor sign-extended byte
  assign hash_new = ((hash_q << 5) + hash_q) ^ {{24{in_i.ch[7]}}, in_i.ch};
  assign cnt_new  = (cnt_q < 9'(MAX_LEN)) ? (cnt_q + 9'd1) : 9'(MAX_LEN + 1);
  assign nbuf_we  = acc && (cnt_q < 9'(MAX_LEN));

  assign fill_sum  = {1'b0, fill_q} + (FILL_W + 1)'(len_q);
  assign used_inc  = CMP_W'(used_q) + CMP_W'(1);
  assign limit_ext = CMP_W'(fill_limit_q);
  assign last_char = ({1'b0, i_q} + 9'd1) == {1'b0, len_q};
  assign idx_ext   = 32'(idx_q);

  assign char_rd_addr = slot_start_q + STORE_AW'(i_q);
  assign char_wr_addr = STORE_AW'(fill_q) + STORE_AW'(i_q);
  assign char_we      = (state_q == S_COPYWR);
  assign slot_ins     = (state_q == S_COPYWR) && last_char;
  assign slot_we      = slot_ins || (state_q == S_CLEAR);

  // sequencer
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    cnt_d       = cnt_q;
    name_hash_d = name_hash_q;
    len_d       = len_q;
    idx_d       = idx_q;
    n_d         = n_q;
    i_d         = i_q;
    used_d      = used_q;
    fill_d      = fill_q;
    clr_d       = clr_q;
    out_vld_d   = 1'b0;
    res_d       = res_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          hash_d = hash_new;
          cnt_d  = cnt_new;
          if (in_i.last) begin
            hash_d      = HASH_START;
            cnt_d       = 9'd0;
            name_hash_d = hash_new;
            len_d       = cnt_new[LEN_W-1:0];
            if (cnt_new > 9'(MAX_LEN)) begin
              out_vld_d        = 1'b1;
              res_d.slot_id    = '0;
              res_d.name_hash  = hash_new;
              res_d.status     = ST_TOO_LONG;
            end else begin
              idx_d   = hash_new[SLOT_W-1:0];
              n_d     = '0;
              state_d = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        i_d = '0;
        if (!slot_vld_q) begin
          if (used_inc >= limit_ext || fill_sum > (FILL_W + 1)'(STORE_BYTES)) begin
            out_vld_d       = 1'b1;
            res_d.slot_id   = '0;
            res_d.name_hash = name_hash_q;
            res_d.status    = ST_FULL;
            state_d         = S_IDLE;
          end else begin
            state_d = S_COPY;
          end
        end else if (slot_hash_q == name_hash_q && slot_len_q == len_q) begin
          state_d = S_CMP;
        end else if (n_q + N_W'(1) == N_W'(SLOTS)) begin
          out_vld_d       = 1'b1;
          res_d.slot_id   = '0;
          res_d.name_hash = name_hash_q;
          res_d.status    = ST_FULL;
          state_d         = S_IDLE;
        end else begin
          idx_d   = idx_q + SLOT_W'(1);
          n_d     = n_q + N_W'(1);
          state_d = S_PROBE;
        end
      end
      S_CMP: begin
        state_d = S_CMPCHK;
      end
      S_CMPCHK: begin
        if (char_rd_q != nbuf_rd_q) begin
          if (n_q + N_W'(1) == N_W'(SLOTS)) begin
            out_vld_d       = 1'b1;
            res_d.slot_id   = '0;
            res_d.name_hash = name_hash_q;
            res_d.status    = ST_FULL;
            state_d         = S_IDLE;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            n_d     = n_q + N_W'(1);
            state_d = S_PROBE;
          end
        end else if (last_char) begin
          out_vld_d       = 1'b1;
          res_d.slot_id   = idx_ext[SLOTID_W-1:0];
          res_d.name_hash = name_hash_q;
          res_d.status    = ST_FOUND;
          state_d         = S_IDLE;
        end else begin
          i_d     = i_q + LEN_W'(1);
          state_d = S_CMP;
        end
      end
      S_COPY: begin
        state_d = S_COPYWR;
      end
      S_COPYWR: begin
        if (last_char) begin
          fill_d          = fill_q + FILL_W'(len_q);
          used_d          = used_q + N_W'(1);
          out_vld_d       = 1'b1;
          res_d.slot_id   = idx_ext[SLOTID_W-1:0];
          res_d.name_hash = name_hash_q;
          res_d.status    = ST_INSERTED;
          state_d         = S_IDLE;
        end else begin
          i_d     = i_q + LEN_W'(1);
          state_d = S_COPY;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      fill_limit_q <= FILL_LIMIT_RST;
      hash_q       <= HASH_START;
      cnt_q        <= '0;
      used_q       <= '0;
      fill_q       <= '0;
      clr_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      hash_q    <= hash_d;
      cnt_q     <= cnt_d;
      used_q    <= used_d;
      fill_q    <= fill_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        fill_limit_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    name_hash_q <= name_hash_d;
    len_q       <= len_d;
    idx_q       <= idx_d;
    n_q         <= n_d;
    i_q         <= i_d;
    res_q       <= res_d;
  end

  // slot table, cleared after reset
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_vld_mem[slot_ins ? idx_q : clr_q] <= slot_ins;
    end
    if (slot_ins) begin
      slot_hash_mem[idx_q]  <= name_hash_q;
      slot_len_mem[idx_q]   <= len_q;
      slot_start_mem[idx_q] <= STORE_AW'(fill_q);
    end
    slot_vld_q   <= slot_vld_mem[idx_q];
    slot_hash_q  <= slot_hash_mem[idx_q];
    slot_len_q   <= slot_len_mem[idx_q];
    slot_start_q <= slot_start_mem[idx_q];
  end

  // character store
  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[char_wr_addr] <= nbuf_rd_q;
    end
    char_rd_q <= char_mem[char_rd_addr];
  end

  // name buffer
  always_ff @(posedge clk_i) begin
    if (nbuf_we) begin
      nbuf_mem[cnt_q[7:0]] <= in_i.ch;
    end
    nbuf_rd_q <= nbuf_mem[i_q];
  end

endmodule
`default_nettype wire
